// File: rtl/core/life_generation_stepper_assert.svh
// Assertion macros shared by the life generation stepper RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef LIFE_GENERATION_STEPPER_ASSERT_SVH
`define LIFE_GENERATION_STEPPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define LGS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LGS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lgs_pkg.sv
// Package for the life generation stepper: constants, register codes,
// result types and the neighbor-count / rule helpers. No dependencies.
`default_nettype none

package lgs_pkg;

    // Row buffer size default
    localparam int MAX_WIDTH_DEF = 32;

    // Configuration port geometry
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;
    localparam int RULE_W = 4;
    localparam int GW_W   = 6;
    localparam int ROW_W  = 16;
    localparam int CNT_W  = 4;

    // Result slots produced per cell and result queue size
    localparam int SLOTS     = 4;
    localparam int RES_DEPTH = 8;
    localparam int RES_AW    = 3;
    localparam int RES_CW    = 4;

    typedef enum logic [CFG_AW-1:0] {
        REG_SURVIVE_LOW  = 3'd0,
        REG_SURVIVE_HIGH = 3'd1,
        REG_BIRTH_LOW    = 3'd2,
        REG_BIRTH_HIGH   = 3'd3,
        REG_GRID_WIDTH   = 3'd4,
        REG_GRID_HEIGHT  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [RULE_W-1:0] survive_low;
        logic [RULE_W-1:0] survive_high;
        logic [RULE_W-1:0] birth_low;
        logic [RULE_W-1:0] birth_high;
    } rule_cfg_t;

    typedef struct packed {
        logic             next_alive;
        logic             just_died;
        logic [CNT_W-1:0] neighbor_count;
        logic             frame_last;
    } result_t;

    // Up to four results for one accepted cell, in delivery order
    typedef struct packed {
        logic    [SLOTS-1:0] valid;
        result_t [SLOTS-1:0] res;
    } result_set_t;

    // Live cells among three bits
    function automatic logic [1:0] pop3(input logic [2:0] v);
        pop3 = {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
    endfunction

    // Birth range wins; otherwise a live cell may survive; otherwise dead
    function automatic result_t apply_rule(input rule_cfg_t rc, input logic alive,
                                           input logic [CNT_W-1:0] cnt,
                                           input logic last);
        result_t r;
        logic    born;
        logic    keep;
        born = (cnt >= rc.birth_low) && (cnt <= rc.birth_high);
        keep = alive && (cnt >= rc.survive_low) && (cnt <= rc.survive_high);
        r.next_alive     = born || keep;
        r.just_died      = alive && !(born || keep);
        r.neighbor_count = cnt;
        r.frame_last     = last;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/lgs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module lgs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and read old contents on a collision
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/lgs_window.sv
// Row buffers, 3x3 window, raster counters and per-cell result evaluation.
// Depends on lgs_pkg and lgs_ram.
`default_nettype none

module lgs_window #(
    parameter int MAX_WIDTH = lgs_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           in_accept,
    input  wire logic                           cell_alive,
    input  wire lgs_pkg::rule_cfg_t             rule_cfg,
    input  wire logic [lgs_pkg::GW_W-1:0]       grid_width,
    input  wire logic [lgs_pkg::ROW_W-1:0]      grid_height,
    output lgs_pkg::result_set_t                res_set
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam logic [lgs_pkg::GW_W-1:0] MAXW = lgs_pkg::GW_W'(MAX_WIDTH);

    logic [CW-1:0]               column_count_reg, column_count_next;
    logic [lgs_pkg::ROW_W-1:0]   row_count_reg, row_count_next;
    logic [8:0]                  window_reg, window_next;
    logic [MAX_WIDTH-1:0]        valid_reg;
    logic                        rd_vld_reg;
    logic                        byp_hit_reg;
    logic [1:0]                  byp_data_reg;

    logic [CW-1:0]               raddr;
    logic [1:0]                  wdata;
    logic [1:0]                  ram_rdata;
    logic [1:0]                  row_data;
    logic [lgs_pkg::GW_W-1:0]    w_eff;
    logic [lgs_pkg::ROW_W-1:0]   h_eff;
    logic                        last_col, last_row;
    logic                        top, mid;
    logic [2:0]                  col;
    logic [8:0]                  win_base;
    logic                        r_ge1;

    // Results of one window position: row above (A) and, in the last row, this row (B)
    function automatic void eval_column(input lgs_pkg::rule_cfg_t rc, input logic [8:0] w,
                                        input logic final_col,
                                        output lgs_pkg::result_t res_a,
                                        output lgs_pkg::result_t res_b);
        logic [2:0]                lc, cc, rc3;
        logic [lgs_pkg::CNT_W-1:0] cnt_a, cnt_b;
        lc  = w[2:0];
        cc  = w[5:3];
        rc3 = w[8:6];
        cnt_a = {2'b00, lgs_pkg::pop3(lc)} + {2'b00, lgs_pkg::pop3(rc3)}
              + {3'b000, cc[0]} + {3'b000, cc[2]};
        cnt_b = {2'b00, lgs_pkg::pop3(lc & 3'b110)} + {2'b00, lgs_pkg::pop3(rc3 & 3'b110)}
              + {3'b000, cc[1]};
        res_a = lgs_pkg::apply_rule(rc, cc[1], cnt_a, 1'b0);
        res_b = lgs_pkg::apply_rule(rc, cc[2], cnt_b, final_col);
    endfunction

    // Effective geometry
    always_comb begin
        if (grid_width == '0) begin
            w_eff = lgs_pkg::GW_W'(1);
        end else if (grid_width > MAXW) begin
            w_eff = MAXW;
        end else begin
            w_eff = grid_width;
        end
        h_eff = (grid_height == '0) ? lgs_pkg::ROW_W'(1) : grid_height;
    end

    assign last_col = ({1'b0, lgs_pkg::GW_W'(column_count_reg)} + 7'd1) >= {1'b0, w_eff};
    assign last_row = ({1'b0, row_count_reg} + 17'd1) >= {1'b0, h_eff};
    assign r_ge1    = (row_count_reg != '0);

    // Counter advance
    always_comb begin
        if (last_col) begin
            column_count_next = '0;
            row_count_next    = last_row ? '0 : row_count_reg + lgs_pkg::ROW_W'(1);
        end else begin
            column_count_next = column_count_reg + CW'(1);
            row_count_next    = row_count_reg;
        end
    end

    // Row buffer: bit 1 upper row, bit 0 middle row; read one cell ahead
    assign raddr = in_accept ? column_count_next : column_count_reg;
    assign wdata = {row_data[0], cell_alive};

    lgs_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_rows (
        .aclk  (aclk),
        .we    (in_accept),
        .waddr (column_count_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // Read data with same-address bypass; never-written entries read dead
    always_comb begin
        if (byp_hit_reg) begin
            row_data = byp_data_reg;
        end else if (rd_vld_reg) begin
            row_data = ram_rdata;
        end else begin
            row_data = 2'b00;
        end
    end

    // New window column: bit 0 row r-2, bit 1 row r-1, bit 2 row r
    assign top      = (row_count_reg >= lgs_pkg::ROW_W'(2)) ? row_data[1] : 1'b0;
    assign mid      = r_ge1 ? row_data[0] : 1'b0;
    assign col      = {cell_alive, mid, top};
    assign win_base = (column_count_reg == '0) ? 9'd0 : window_reg;
    assign window_next = {col, win_base[8:3]};

    // Result slots for this cell
    always_comb begin
        lgs_pkg::result_t ra0, rb0, ra1, rb1;
        eval_column(rule_cfg, window_next, 1'b0, ra0, rb0);
        eval_column(rule_cfg, {3'b000, window_next[8:3]}, 1'b1, ra1, rb1);
        res_set.res[0]   = ra0;
        res_set.res[1]   = rb0;
        res_set.res[2]   = ra1;
        res_set.res[3]   = rb1;
        res_set.valid[0] = in_accept && (column_count_reg != '0) && r_ge1;
        res_set.valid[1] = in_accept && (column_count_reg != '0) && last_row;
        res_set.valid[2] = in_accept && last_col && r_ge1;
        res_set.valid[3] = in_accept && last_col && last_row;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            window_reg       <= '0;
            valid_reg        <= '0;
            rd_vld_reg       <= 1'b0;
            byp_hit_reg      <= 1'b0;
        end else begin
            rd_vld_reg  <= valid_reg[raddr];
            byp_hit_reg <= in_accept && (column_count_reg == raddr);
            if (in_accept) begin
                column_count_reg            <= column_count_next;
                row_count_reg               <= row_count_next;
                window_reg                  <= window_next;
                valid_reg[column_count_reg] <= 1'b1;
            end
        end
    end

    // Bypass payload
    always_ff @(posedge aclk) begin
        byp_data_reg <= wdata;
    end

endmodule

`default_nettype wire

// File: rtl/core/lgs_result_queue.sv
// Result queue: takes up to four results per cycle in order, delivers one.
// Depends on lgs_pkg and life_generation_stepper_assert.svh.
`default_nettype none

`include "life_generation_stepper_assert.svh"

module lgs_result_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire lgs_pkg::result_set_t push_set,
    output logic                      room,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output lgs_pkg::result_t          m_res
);

    lgs_pkg::result_t              entry_reg [lgs_pkg::RES_DEPTH];
    logic [lgs_pkg::RES_AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [lgs_pkg::RES_CW-1:0]    count_reg, count_next;
    logic [lgs_pkg::RES_AW-1:0]    pos [lgs_pkg::SLOTS];
    logic [lgs_pkg::RES_CW-1:0]    push_cnt;
    logic                          pop;

    // Packed write positions of the valid slots
    always_comb begin
        logic [lgs_pkg::RES_CW-1:0] offs;
        offs = '0;
        for (int i = 0; i < lgs_pkg::SLOTS; i++) begin
            pos[i] = wr_ptr_reg + offs[lgs_pkg::RES_AW-1:0];
            offs   = offs + lgs_pkg::RES_CW'(push_set.valid[i]);
        end
        push_cnt = offs;
    end

    assign pop        = m_valid && m_ready;
    assign count_next = count_reg + push_cnt - lgs_pkg::RES_CW'(pop);
    assign room       = (count_reg <= lgs_pkg::RES_CW'(lgs_pkg::RES_DEPTH - lgs_pkg::SLOTS));
    assign m_valid    = (count_reg != '0);
    assign m_res      = entry_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_cnt[lgs_pkg::RES_AW-1:0];
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + lgs_pkg::RES_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        for (int i = 0; i < lgs_pkg::SLOTS; i++) begin
            if (push_set.valid[i]) begin
                entry_reg[pos[i]] <= push_set.res[i];
            end
        end
    end

    `LGS_ASSERT_IMP(a_no_overflow, aclk, aresetn, 1'b1,
        count_reg <= lgs_pkg::RES_CW'(lgs_pkg::RES_DEPTH), "result queue overflow")
    `LGS_ASSERT_IMP(a_push_with_room, aclk, aresetn, push_cnt != '0, room,
        "results pushed without room")
    `LGS_ASSERT_NXT(a_pop_drains, aclk, aresetn, pop && (push_cnt == '0),
        count_reg == $past(count_reg) - lgs_pkg::RES_CW'(1), "pop did not drain one")
    `LGS_ASSERT_NXT(a_push_fills, aclk, aresetn, !pop && (push_cnt != '0),
        count_reg == $past(count_reg) + $past(push_cnt), "push count mismatch")

endmodule

`default_nettype wire

// File: rtl/core/life_generation_stepper.sv
// Life generation stepper: one cell is taken per cycle while s_ready is high, in raster order
// (x fastest), and the next-generation state, a just-died flag, the live-neighbor count and a
// frame-last marker come out per cell through a registered result queue, one result per cycle
// while m_ready is high. Results lag one row plus one cell; in the last row of a frame with more
// than one row two results are due per cell, and the final cell of a row in the last row gives up
// to four. An input cell is taken whenever the eight-entry result queue has room for four results,
// so rows other than the last (and one-row frames) run at one cell per cycle while results drain,
// and the last row of a taller frame runs slower, bounded by the single result port. Rule ranges
// and grid size are written through the cfg port; the user must write them only while the block
// is idle, which the block does not enforce itself; cells outside the grid count as dead.
// Depends on lgs_pkg, lgs_window, lgs_result_queue.
`default_nettype none

module life_generation_stepper #(
    parameter int MAX_WIDTH = lgs_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // Configuration write port
    input  wire logic                         cfg_we,
    input  wire logic [lgs_pkg::CFG_AW-1:0]   cfg_addr,
    input  wire logic [lgs_pkg::CFG_DW-1:0]   cfg_data,
    // Cell input
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_cell_alive,
    // Results
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_next_alive,
    output logic                              m_just_died,
    output logic [lgs_pkg::CNT_W-1:0]         m_neighbor_count,
    output logic                              m_frame_last
);

    lgs_pkg::rule_cfg_t             rule_reg;
    logic [lgs_pkg::GW_W-1:0]       grid_width_reg;
    logic [lgs_pkg::ROW_W-1:0]      grid_height_reg;
    logic                           in_accept;
    logic                           room;
    lgs_pkg::result_set_t           res_set;
    lgs_pkg::result_t               head;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_reg.survive_low  <= lgs_pkg::RULE_W'(2);
            rule_reg.survive_high <= lgs_pkg::RULE_W'(3);
            rule_reg.birth_low    <= lgs_pkg::RULE_W'(3);
            rule_reg.birth_high   <= lgs_pkg::RULE_W'(3);
            grid_width_reg        <= lgs_pkg::GW_W'(32);
            grid_height_reg       <= lgs_pkg::ROW_W'(32);
        end else if (cfg_we) begin
            case (lgs_pkg::cfg_reg_t'(cfg_addr))
                lgs_pkg::REG_SURVIVE_LOW:  rule_reg.survive_low  <= cfg_data[lgs_pkg::RULE_W-1:0];
                lgs_pkg::REG_SURVIVE_HIGH: rule_reg.survive_high <= cfg_data[lgs_pkg::RULE_W-1:0];
                lgs_pkg::REG_BIRTH_LOW:    rule_reg.birth_low    <= cfg_data[lgs_pkg::RULE_W-1:0];
                lgs_pkg::REG_BIRTH_HIGH:   rule_reg.birth_high   <= cfg_data[lgs_pkg::RULE_W-1:0];
                lgs_pkg::REG_GRID_WIDTH:   grid_width_reg        <= cfg_data[lgs_pkg::GW_W-1:0];
                lgs_pkg::REG_GRID_HEIGHT:  grid_height_reg       <= cfg_data[lgs_pkg::ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input handshake
    assign s_ready   = room;
    assign in_accept = s_valid && room;

    lgs_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .cell_alive  (s_cell_alive),
        .rule_cfg    (rule_reg),
        .grid_width  (grid_width_reg),
        .grid_height (grid_height_reg),
        .res_set     (res_set)
    );

    lgs_result_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_set (res_set),
        .room     (room),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (head)
    );

    // Result fields
    assign m_next_alive     = head.next_alive;
    assign m_just_died      = head.just_died;
    assign m_neighbor_count = head.neighbor_count;
    assign m_frame_last     = head.frame_last;

endmodule

`default_nettype wire
